FILE: rtl/evcd_pkg.sv
// Shared types, codes and default sizes for the vendor command dispatcher.
package evcd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int STRING_LEN_DEF       = 32;
  localparam int PARAM_DEPTH_DEF      = 32;
  localparam int ZERO_REPLY_BYTES_DEF = 2;

  // Command and sub-command bytes.
  localparam logic [7:0] CMD_VENDOR = 8'h59;
  localparam logic [7:0] SUB_PARAMS = 8'hD0;
  localparam logic [7:0] SUB_SERIAL = 8'hD5;
  localparam logic [7:0] SUB_MAKER  = 8'hD6;
  localparam logic [7:0] ZERO_REPLY = 8'h00;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DATA_PORT = 2'd0;
  localparam logic [1:0] CFG_CMD_PORT  = 2'd1;
  localparam logic [1:0] CFG_MAX_PARAM = 2'd2;

  // Result kinds.
  localparam logic KIND_RESP  = 1'b0;
  localparam logic KIND_PARAM = 1'b1;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_FLUSH    = 3'd2,
    ACT_LOAD_SER = 3'd3,
    ACT_LOAD_MAK = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNSUP     = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec_fire;
    logic drain_read;
    logic drain_fire;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
    logic has_drain;
    logic drain_last;
  } ctrl_sts_t;

endpackage

FILE: rtl/evcd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module evcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/evcd_ctrl.sv
// Sequencer that steps each beat through lookup, execute and parameter drain.
module evcd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  evcd_pkg::ctrl_sts_t   sts,
  output evcd_pkg::ctrl_cmd_t   cmd
);

  import evcd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EXEC = 5'b00100,
    S_DRD  = 5'b01000,
    S_DOUT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.lookup     = (state == S_LOOK);
    cmd.exec_fire  = (state == S_EXEC) && sts.out_free;
    cmd.drain_read = (state == S_DRD);
    cmd.drain_fire = (state == S_DOUT) && sts.out_free;
    in_stall       = (state != S_IDLE);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: state_next = S_EXEC;
      S_EXEC: begin
        if (sts.out_free) state_next = sts.has_drain ? S_DRD : S_IDLE;
      end
      S_DRD:  state_next = S_DOUT;
      S_DOUT: begin
        if (sts.out_free) state_next = sts.drain_last ? S_IDLE : S_DRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/evcd_dpath.sv
// Datapath: configuration, protocol state, stores and the output register.
module evcd_dpath #(
  parameter int STRING_LEN       = evcd_pkg::STRING_LEN_DEF,
  parameter int PARAM_DEPTH      = evcd_pkg::PARAM_DEPTH_DEF,
  parameter int ZERO_REPLY_BYTES = evcd_pkg::ZERO_REPLY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [2:0]          action,
  input  logic [15:0]         port,
  input  logic [7:0]          write_byte,
  input  logic [4:0]          char_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [1:0]          status,
  output logic [7:0]          read_byte,
  output logic                dispatched,
  output logic [5:0]          param_count,
  output logic [7:0]          param_byte,
  output logic                last,
  input  evcd_pkg::ctrl_cmd_t cmd,
  output evcd_pkg::ctrl_sts_t sts
);

  import evcd_pkg::*;

  localparam int SAW = (STRING_LEN > 1) ? $clog2(STRING_LEN) : 1;
  localparam int PAW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam logic [5:0] STR_LEN6   = 6'(STRING_LEN);
  localparam logic [5:0] PDEPTH6    = 6'(PARAM_DEPTH);
  localparam logic [1:0] ZERO_BYTES = 2'(ZERO_REPLY_BYTES);

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_WAIT_SUB = 5'b00010,
    MODE_COLLECT  = 5'b00100,
    MODE_READ     = 5'b01000,
    MODE_ZERO     = 5'b10000
  } mode_t;

  // Configuration.
  logic [15:0] data_addr;
  logic [15:0] cmd_addr;
  logic [5:0]  max_param;

  // Captured beat.
  logic [2:0]  act_q;
  logic [15:0] port_q;
  logic [7:0]  wb_q;
  logic [4:0]  ci_q;

  // Protocol state.
  mode_t       mode;
  mode_t       mode_next;
  logic [7:0]  pend;
  logic [7:0]  pend_next;
  logic [5:0]  fill;
  logic [5:0]  fill_next;
  logic [5:0]  sri;
  logic [5:0]  sri_next;
  logic [1:0]  zrc;
  logic [1:0]  zrc_next;

  logic [STRING_LEN-1:0] ser_vld;
  logic [STRING_LEN-1:0] mak_vld;
  logic                  str_hit;
  logic [5:0]            dcount;
  logic [5:0]            drain_idx;

  // Execute-step results.
  status_t     st_c;
  logic [7:0]  rb_c;
  logic        disp_c;
  logic [5:0]  dcount_c;
  logic        pwe_c;
  logic        ser_we_c;
  logic        mak_we_c;
  logic [5:0]  cap;
  logic [5:0]  fill_cur;
  logic [1:0]  zrc_inc;
  logic        ci_ok;
  logic [5:0]  ci6;
  logic [7:0]  str_byte;
  logic        sri_ok;

  logic [7:0]  ser_q;
  logic [7:0]  mak_q;
  logic [7:0]  par_q;

  assign ci6    = {1'b0, ci_q};
  assign ci_ok  = (ci6 < STR_LEN6);
  assign sri_ok = (sri < STR_LEN6);
  assign cap    = ((max_param == 6'd0) || (max_param > PDEPTH6)) ? PDEPTH6 : max_param;
  assign str_byte = str_hit ? ((pend == SUB_SERIAL) ? ser_q : mak_q) : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_addr <= 16'd98;
      cmd_addr  <= 16'd102;
      max_param <= 6'd0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_DATA_PORT: data_addr <= cfg_data;
        CFG_CMD_PORT:  cmd_addr  <= cfg_data;
        CFG_MAX_PARAM: max_param <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      port_q <= port;
      wb_q   <= write_byte;
      ci_q   <= char_index;
    end
  end

  // Lookup: sample the valid bit of the string entry that a read would return.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      str_hit <= sri_ok && ((pend == SUB_SERIAL) ? ser_vld[sri[SAW-1:0]]
                                                 : mak_vld[sri[SAW-1:0]]);
    end
  end

  always_comb begin
    st_c      = ST_UNSUP;
    rb_c      = 8'h00;
    disp_c    = 1'b0;
    dcount_c  = fill;
    pwe_c     = 1'b0;
    ser_we_c  = 1'b0;
    mak_we_c  = 1'b0;
    mode_next = mode;
    pend_next = pend;
    fill_next = fill;
    sri_next  = sri;
    zrc_next  = zrc;
    zrc_inc   = zrc + 2'd1;
    fill_cur  = (fill < PDEPTH6) ? (fill + 6'd1) : fill;
    case (act_q)
      ACT_WRITE: begin
        if (port_q == cmd_addr) begin
          if (mode == MODE_COLLECT) begin
            disp_c   = 1'b1;
            dcount_c = fill;
          end
          fill_next = 6'd0;
          pend_next = 8'h00;
          sri_next  = 6'd0;
          zrc_next  = 2'd0;
          if (wb_q == CMD_VENDOR) begin
            mode_next = MODE_WAIT_SUB;
            st_c      = ST_OK;
          end else begin
            mode_next = MODE_IDLE;
            st_c      = ST_UNSUP;
          end
        end else if (port_q == data_addr) begin
          case (mode)
            MODE_WAIT_SUB: begin
              st_c      = ST_OK;
              pend_next = wb_q;
              if (wb_q == SUB_PARAMS) begin
                mode_next = MODE_COLLECT;
                fill_next = 6'd0;
              end else if ((wb_q == SUB_SERIAL) || (wb_q == SUB_MAKER)) begin
                mode_next = MODE_READ;
                sri_next  = 6'd0;
              end else begin
                mode_next = MODE_ZERO;
                zrc_next  = 2'd0;
              end
            end
            MODE_COLLECT: begin
              st_c  = ST_OK;
              pwe_c = (fill < PDEPTH6);
              if (fill_cur >= cap) begin
                disp_c    = 1'b1;
                dcount_c  = fill_cur;
                fill_next = 6'd0;
                mode_next = MODE_IDLE;
              end else begin
                fill_next = fill_cur;
              end
            end
            default: st_c = ST_NOT_READY;
          endcase
        end
      end
      ACT_READ: begin
        if (port_q == data_addr) begin
          case (mode)
            MODE_ZERO: begin
              st_c     = ST_OK;
              rb_c     = ZERO_REPLY;
              zrc_next = zrc_inc;
              if (zrc_inc >= ZERO_BYTES) mode_next = MODE_IDLE;
            end
            MODE_READ: begin
              if ((pend == SUB_SERIAL) || (pend == SUB_MAKER)) begin
                st_c = ST_OK;
                rb_c = str_byte;
                if (str_byte == 8'h00) begin
                  mode_next = MODE_IDLE;
                end else begin
                  sri_next = sri + 6'd1;
                end
              end
            end
            default: st_c = ST_NOT_READY;
          endcase
        end
      end
      ACT_FLUSH: begin
        if (mode == MODE_COLLECT) begin
          disp_c    = 1'b1;
          dcount_c  = fill;
          fill_next = 6'd0;
          mode_next = MODE_IDLE;
          st_c      = ST_OK;
        end else begin
          st_c = ST_NOT_READY;
        end
      end
      ACT_LOAD_SER: begin
        ser_we_c = ci_ok;
        st_c     = ST_OK;
      end
      ACT_LOAD_MAK: begin
        mak_we_c = ci_ok;
        st_c     = ST_OK;
      end
      default: st_c = ST_UNSUP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pend    <= 8'h00;
      fill    <= 6'd0;
      sri     <= 6'd0;
      zrc     <= 2'd0;
      ser_vld <= '0;
      mak_vld <= '0;
    end else if (cmd.exec_fire) begin
      mode <= mode_next;
      pend <= pend_next;
      fill <= fill_next;
      sri  <= sri_next;
      zrc  <= zrc_next;
      if (ser_we_c) ser_vld[ci6[SAW-1:0]] <= 1'b1;
      if (mak_we_c) mak_vld[ci6[SAW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) begin
      dcount    <= disp_c ? dcount_c : 6'd0;
      drain_idx <= 6'd0;
    end else if (cmd.drain_fire) begin
      drain_idx <= drain_idx + 6'd1;
    end
  end

  evcd_ram #(.WIDTH(8), .DEPTH(STRING_LEN)) u_ser_ram (
    .clk   (clk),
    .we    (cmd.exec_fire && ser_we_c),
    .waddr (ci6[SAW-1:0]),
    .wdata (wb_q),
    .re    (cmd.lookup),
    .raddr (sri[SAW-1:0]),
    .rdata (ser_q)
  );

  evcd_ram #(.WIDTH(8), .DEPTH(STRING_LEN)) u_mak_ram (
    .clk   (clk),
    .we    (cmd.exec_fire && mak_we_c),
    .waddr (ci6[SAW-1:0]),
    .wdata (wb_q),
    .re    (cmd.lookup),
    .raddr (sri[SAW-1:0]),
    .rdata (mak_q)
  );

  evcd_ram #(.WIDTH(8), .DEPTH(PARAM_DEPTH)) u_par_ram (
    .clk   (clk),
    .we    (cmd.exec_fire && pwe_c),
    .waddr (fill[PAW-1:0]),
    .wdata (wb_q),
    .re    (cmd.drain_read),
    .raddr (drain_idx[PAW-1:0]),
    .rdata (par_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_fire || cmd.drain_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) begin
      kind        <= KIND_RESP;
      status      <= st_c;
      read_byte   <= rb_c;
      dispatched  <= disp_c;
      param_count <= disp_c ? dcount_c : 6'd0;
      param_byte  <= 8'h00;
      last        <= !(disp_c && (dcount_c != 6'd0));
    end else if (cmd.drain_fire) begin
      kind        <= KIND_PARAM;
      status      <= ST_OK;
      read_byte   <= 8'h00;
      dispatched  <= 1'b1;
      param_count <= dcount;
      param_byte  <= par_q;
      last        <= (drain_idx + 6'd1 == dcount);
    end
  end

  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.has_drain  = disp_c && (dcount_c != 6'd0);
  assign sts.drain_last = (drain_idx + 6'd1 == dcount);

endmodule

FILE: rtl/ec_vendor_command_dispatch.sv
// Top level of the embedded-controller vendor command dispatcher.
// The access response beat is loaded into the output register by the execute step,
// after the capture and lookup steps. A new input beat is taken only once the
// sequencer is idle again, after any forwarded parameter bytes have been drained.
// Reset: synchronous rst restores the port addresses and capacity, idles the protocol,
// and clears the serial and maker strings at once through per-entry valid bits.
module ec_vendor_command_dispatch #(
  parameter int STRING_LEN       = evcd_pkg::STRING_LEN_DEF,
  parameter int PARAM_DEPTH      = evcd_pkg::PARAM_DEPTH_DEF,
  parameter int ZERO_REPLY_BYTES = evcd_pkg::ZERO_REPLY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [15:0] port,
  input  logic [7:0]  write_byte,
  input  logic [4:0]  char_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [7:0]  read_byte,
  output logic        dispatched,
  output logic [5:0]  param_count,
  output logic [7:0]  param_byte,
  output logic        last
);

  import evcd_pkg::*;

  // The controller owns sequencing only; every stored value of the protocol
  // (mode, sub-command, fill level, string index, the three stores) lives in
  // the datapath. Each input beat is captured, then the string stores are read
  // in a lookup cycle, then the execute cycle updates the protocol state and
  // loads the access response into the output register. A dispatch then
  // drains the collected parameter bytes, each read from the parameter store
  // and sent as its own result beat. The output register lets the next input
  // beat be taken while the final result beat still waits downstream.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  evcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  evcd_dpath #(
    .STRING_LEN       (STRING_LEN),
    .PARAM_DEPTH      (PARAM_DEPTH),
    .ZERO_REPLY_BYTES (ZERO_REPLY_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .port        (port),
    .write_byte  (write_byte),
    .char_index  (char_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .read_byte   (read_byte),
    .dispatched  (dispatched),
    .param_count (param_count),
    .param_byte  (param_byte),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

FILE: rtl/evcd_checker.sv
// Port-level checks for the vendor command dispatcher and their bind.
module evcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [1:0]  status,
  input logic [7:0]  read_byte,
  input logic        dispatched,
  input logic [5:0]  param_count,
  input logic [7:0]  param_byte,
  input logic        last
);

  import evcd_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(param_byte)
      && $stable(last))
    else $error("result beat changed while stalled");

  // Forwarded bytes always report a successful, nonempty dispatch.
  a_fwd_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_PARAM) |-> dispatched && (status == ST_OK)
      && (read_byte == 8'h00) && (param_count != 6'd0))
    else $error("forwarded byte with bad fields");

  // A response without a dispatch ends its run and counts nothing.
  a_resp_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_RESP) && !dispatched |-> last && (param_count == 6'd0))
    else $error("response without dispatch is not last");

  // Items are handled one at a time: an accepted beat blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

endmodule

bind ec_vendor_command_dispatch evcd_checker u_evcd_checker (.*);
